@@ rtl/core/erm_pkg.sv @@
// erm_pkg: shared constants, types and helpers for the euler rotation block
// no dependencies
`timescale 1ns / 1ps

package erm_pkg;

  localparam int CordicStages = 16;
  localparam int FracBits     = 15;
  localparam int TableLen     = 24;
  localparam int NumStages    = (CordicStages > TableLen) ? TableLen : CordicStages;

  // cordic datapath widths: x,y in Q2.30 with headroom, z in 2^-32 turn
  localparam int XyW = 34;
  localparam int ZW  = 34;
  // trig values after narrowing: +-2^FracBits needs FracBits+2 bits
  localparam int TrigW = FracBits + 2;
  // product and sum headroom
  localparam int ProdW = 2 * TrigW;
  localparam int SumW  = TrigW + 3;

  localparam int StageIdxW = $clog2(NumStages + 1);

  localparam logic signed [XyW-1:0] CordicGain = XyW'(64'sd652032874);

  typedef logic signed [XyW-1:0]   xy_t;
  typedef logic signed [ZW-1:0]    z_t;
  typedef logic signed [TrigW-1:0] trig_t;
  typedef logic signed [SumW-1:0]  sum_t;

  // one angle in flight through a cordic cell
  typedef struct packed {
    xy_t  x;
    xy_t  y;
    z_t   z;
    logic neg;
  } rot_t;

  // per-angle lane bundle for the three angles
  typedef struct packed {
    rot_t roll;
    rot_t pitch;
    rot_t yaw;
  } rot3_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic z_t atan_lut(input logic [StageIdxW-1:0] idx);
    logic [31:0] v;
    begin
      case (idx)
        5'd0:    v = 32'd536870912;
        5'd1:    v = 32'd316933406;
        5'd2:    v = 32'd167458907;
        5'd3:    v = 32'd85004756;
        5'd4:    v = 32'd42667331;
        5'd5:    v = 32'd21354465;
        5'd6:    v = 32'd10679838;
        5'd7:    v = 32'd5340245;
        5'd8:    v = 32'd2670163;
        5'd9:    v = 32'd1335087;
        5'd10:   v = 32'd667544;
        5'd11:   v = 32'd333772;
        5'd12:   v = 32'd166886;
        5'd13:   v = 32'd83443;
        5'd14:   v = 32'd41722;
        5'd15:   v = 32'd20861;
        5'd16:   v = 32'd10430;
        5'd17:   v = 32'd5215;
        5'd18:   v = 32'd2608;
        5'd19:   v = 32'd1304;
        5'd20:   v = 32'd652;
        5'd21:   v = 32'd326;
        5'd22:   v = 32'd163;
        5'd23:   v = 32'd81;
        default: v = 32'd0;
      endcase
      atan_lut = z_t'(v);
    end
  endfunction

  // rounded product back to FracBits fraction bits
  function automatic sum_t mul_round(input trig_t a, input trig_t b);
    logic signed [ProdW-1:0] p;
    begin
      p = (ProdW'(a) * ProdW'(b)) + (ProdW'(1) <<< (FracBits - 1));
      mul_round = SumW'(p >>> FracBits);
    end
  endfunction

  // product of a rounded value that may exceed trig range by one bit
  function automatic sum_t mul_round_s(input sum_t a, input trig_t b);
    logic signed [SumW+TrigW-1:0] p;
    begin
      p = ((SumW + TrigW)'(a) * (SumW + TrigW)'(b))
        + ((SumW + TrigW)'(1) <<< (FracBits - 1));
      mul_round_s = SumW'(p >>> FracBits);
    end
  endfunction

  // rescale to Q1.15 and saturate
  function automatic logic signed [15:0] to_q15(input sum_t e);
    logic signed [SumW+16:0] t;
    begin
      if (FracBits > 15) begin
        t = ((SumW + 17)'(e) + ((SumW + 17)'(1) <<< ((FracBits > 15) ? FracBits - 16 : 0)))
          >>> ((FracBits > 15) ? FracBits - 15 : 0);
      end else begin
        t = (SumW + 17)'(e) <<< ((FracBits < 15) ? 15 - FracBits : 0);
      end
      if (t > (SumW + 17)'(32767))
        to_q15 = 16'sh7fff;
      else if (t < -(SumW + 17)'(32768))
        to_q15 = -16'sh8000;
      else
        to_q15 = t[15:0];
    end
  endfunction

endpackage

@@ rtl/core/erm_cordic_cell.sv @@
// erm_cordic_cell: one micro-rotation of the cordic chain for three angles
// depends on erm_pkg
`timescale 1ns / 1ps

module erm_cordic_cell (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [erm_pkg::StageIdxW-1:0] stage_i,
  input  erm_pkg::rot3_t              rot_i,
  output erm_pkg::rot3_t              rot_o
);
  import erm_pkg::*;

  rot3_t rot_d, rot_q;

  function automatic rot_t rotate(input rot_t r, input logic [StageIdxW-1:0] s);
    rot_t o;
    z_t   t;
    begin
      t = atan_lut(s);
      o = r;
      if (r.z >= 0) begin
        o.x = r.x - (r.y >>> s);
        o.y = r.y + (r.x >>> s);
        o.z = r.z - t;
      end else begin
        o.x = r.x + (r.y >>> s);
        o.y = r.y - (r.x >>> s);
        o.z = r.z + t;
      end
      rotate = o;
    end
  endfunction

  // rotate all three lanes
  always_comb begin
    rot_d.roll  = rotate(rot_i.roll, stage_i);
    rot_d.pitch = rotate(rot_i.pitch, stage_i);
    rot_d.yaw   = rotate(rot_i.yaw, stage_i);
  end

  // payload register, advances with the pipe
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
    end
  end

  assign rot_o = rot_q;

endmodule

@@ rtl/core/erm_matrix.sv @@
// erm_matrix: narrows cordic results and forms the nine rotation entries
// depends on erm_pkg
`timescale 1ns / 1ps

module erm_matrix (
  input  logic           clk_i,
  input  logic           en_i,
  input  erm_pkg::rot3_t rot_i,
  output logic [143:0]   entries_o
);
  import erm_pkg::*;

  trig_t sr_q, cr_q, sp_q, cp_q, sy_q, cy_q;
  trig_t sr_d, cr_d, sp_d, cp_d, sy_d, cy_d;
  sum_t  cysp_q, sysp_q, cycp_q, sycr_q, sysr_q, sycp_q, cycr_q, cysr_q, cpsr_q, cpcr_q;
  trig_t sr2_q, cr2_q, sp2_q;
  logic [143:0] ent_q;

  function automatic trig_t narrow(input xy_t v, input logic neg);
    xy_t w;
    xy_t r;
    begin
      w = neg ? -v : v;
      r = (w + (XyW'(1) <<< (29 - FracBits))) >>> (30 - FracBits);
      if (r > (XyW'(1) <<< FracBits))
        r = XyW'(1) <<< FracBits;
      else if (r < -(XyW'(1) <<< FracBits))
        r = -(XyW'(1) <<< FracBits);
      narrow = TrigW'(r);
    end
  endfunction

  // narrow sines and cosines
  always_comb begin
    cr_d = narrow(rot_i.roll.x, rot_i.roll.neg);
    sr_d = narrow(rot_i.roll.y, rot_i.roll.neg);
    cp_d = narrow(rot_i.pitch.x, rot_i.pitch.neg);
    sp_d = narrow(rot_i.pitch.y, rot_i.pitch.neg);
    cy_d = narrow(rot_i.yaw.x, rot_i.yaw.neg);
    sy_d = narrow(rot_i.yaw.y, rot_i.yaw.neg);
  end

  // stage a: trig registers; stage b: pair products; stage c: triples and output
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q <= sr_d; cr_q <= cr_d; sp_q <= sp_d;
      cp_q <= cp_d; sy_q <= sy_d; cy_q <= cy_d;

      cysp_q <= mul_round(cy_q, sp_q);
      sysp_q <= mul_round(sy_q, sp_q);
      cycp_q <= mul_round(cy_q, cp_q);
      sycr_q <= mul_round(sy_q, cr_q);
      sysr_q <= mul_round(sy_q, sr_q);
      sycp_q <= mul_round(sy_q, cp_q);
      cycr_q <= mul_round(cy_q, cr_q);
      cysr_q <= mul_round(cy_q, sr_q);
      cpsr_q <= mul_round(cp_q, sr_q);
      cpcr_q <= mul_round(cp_q, cr_q);
      sr2_q  <= sr_q; cr2_q <= cr_q; sp2_q <= sp_q;

      ent_q[15:0]    <= to_q15(cycp_q);
      ent_q[31:16]   <= to_q15(-sycr_q + mul_round_s(cysp_q, sr2_q));
      ent_q[47:32]   <= to_q15(-sysr_q - mul_round_s(cysp_q, cr2_q));
      ent_q[63:48]   <= to_q15(sycp_q);
      ent_q[79:64]   <= to_q15(cycr_q + mul_round_s(sysp_q, sr2_q));
      ent_q[95:80]   <= to_q15(cysr_q - mul_round_s(sysp_q, cr2_q));
      ent_q[111:96]  <= to_q15(SumW'(sp2_q));
      ent_q[127:112] <= to_q15(-cpsr_q);
      ent_q[143:128] <= to_q15(cpcr_q);
    end
  end

  assign entries_o = ent_q;

endmodule

@@ rtl/core/euler_rotation_matrix.sv @@
// euler_rotation_matrix: top level, roll/pitch/yaw to 3x3 rotation entries
// depends on erm_pkg, erm_cordic_cell, erm_matrix
`timescale 1ns / 1ps

// Usage:
//  s_axis carries one angle triple per transfer, three signed binary angles
//  with pi/32768 per unit. m_axis returns the nine Q1.15 entries of the
//  rotation block, row major, one result transfer per input transfer.
//  Structure: a row of NumStages cordic cells, one micro-rotation each,
//  then three registered steps (narrow, pair products, triple products and
//  rescale). One item is taken every cycle while the output is drained.
//  The whole pipe advances as one: a stall at m_axis (tready low with a
//  result held) freezes every stage and drops s_axis_tready, so no result
//  is lost. Reset clears the valid bits of all stages; payload registers
//  are not reset. The block has no state between items.
module euler_rotation_matrix (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // roll_angle [15:0], pitch_angle [31:16], yaw_angle [47:32]
  input  logic [47:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // entry_r0c0..r2c2, 16 bits each from bit 0 up, row major
  output logic [143:0] m_axis_tdata
);
  import erm_pkg::*;

  localparam int Depth = NumStages + 4;

  logic [Depth-1:0] vld_q;
  logic             adv;
  rot3_t            chain [NumStages+1];
  rot3_t            in_q;

  function automatic rot_t fold(input logic [15:0] a);
    rot_t r;
    logic signed [15:0] s;
    begin
      s = a;
      r.neg = (s > 16'sd16384) || (s < -16'sd16384);
      if (r.neg) s = s + 16'sh8000;
      r.x = CordicGain;
      r.y = '0;
      r.z = ZW'(s) <<< 16;
      fold = r;
    end
  endfunction

  // whole pipe moves when the output slot is free or being drained
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[Depth-1];

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
    end
  end

  // input register with quadrant fold
  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q.roll  <= fold(s_axis_tdata[15:0]);
      in_q.pitch <= fold(s_axis_tdata[31:16]);
      in_q.yaw   <= fold(s_axis_tdata[47:32]);
    end
  end

  assign chain[0] = in_q;

  // row of cordic cells
  for (genvar g = 0; g < NumStages; g++) begin : g_cell
    erm_cordic_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (adv),
      .stage_i (StageIdxW'(g)),
      .rot_i   (chain[g]),
      .rot_o   (chain[g+1])
    );
  end

  // narrowing and matrix products
  erm_matrix u_matrix (
    .clk_i     (clk_i),
    .en_i      (adv),
    .rot_i     (chain[NumStages]),
    .entries_o (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // a stalled result keeps its valid
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped during stall");
  // no input taken while the pipe is frozen
  a_frz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipe moved while frozen");
  // an accepted item enters the first stage of the valid pipe
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s_axis_tvalid |=> vld_q[0])
    else $error("accepted item lost");
`endif

endmodule
